### hw/rtl/ntt_pkg.sv
// Package: shared types and constants for the netlist text tokenizer.
`default_nettype none
package ntt_pkg;
  localparam int KwChars = 9;
  localparam int LineBits = 24;
  localparam int ColBits = 16;
  localparam int KlenBits = $clog2(KwChars + 2);
  localparam logic [LineBits-1:0] LineTop = '1;
  localparam logic [ColBits-1:0] ColTop = '1;
  localparam int QDepth = 16;
  localparam int QPtrBits = $clog2(QDepth);
  localparam int CntBits = QPtrBits + 1;

  typedef enum logic [3:0] {
    M_IDLE, M_INT, M_TICK, M_HEX, M_DEC, M_BIN, M_IDENT, M_ESC, M_LPAREN, M_SLASH,
    M_ATTR, M_ATTR_STAR, M_COMMENT, M_COMMENT_STAR, M_LINE_COMMENT
  } mode_t;

  localparam logic [1:0] KIND_VAL = 2'd0;
  localparam logic [1:0] KIND_TOK = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [1:0] BASE_PLAIN = 2'd0;
  localparam logic [1:0] BASE_HEX = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_BIN = 2'd3;

  localparam logic [4:0] PUNCT_NONE = 5'd0;
  localparam logic [4:0] TK_INT = 5'd0;
  localparam logic [4:0] TK_IDENT = 5'd1;
  localparam logic [4:0] TK_ATTR = 5'd2;
  localparam logic [4:0] TK_LPAREN = 5'd3;
  localparam logic [4:0] TK_RPAREN = 5'd4;
  localparam logic [4:0] TK_LBRACK = 5'd5;
  localparam logic [4:0] TK_RBRACK = 5'd6;
  localparam logic [4:0] TK_LBRACE = 5'd7;
  localparam logic [4:0] TK_RBRACE = 5'd8;
  localparam logic [4:0] TK_EQ = 5'd9;
  localparam logic [4:0] TK_COMMA = 5'd10;
  localparam logic [4:0] TK_DOT = 5'd11;
  localparam logic [4:0] TK_SEMI = 5'd12;
  localparam logic [4:0] TK_COLON = 5'd13;
  localparam logic [4:0] TK_SLASH = 5'd14;
  localparam logic [4:0] TK_KW0 = 5'd15;
  localparam logic [4:0] TK_WIRE = 5'd15;
  localparam logic [4:0] TK_MODULE = 5'd16;
  localparam logic [4:0] TK_ENDMODULE = 5'd17;
  localparam logic [4:0] TK_ASSIGN = 5'd18;
  localparam logic [4:0] TK_INPUT = 5'd19;
  localparam logic [4:0] TK_OUTPUT = 5'd20;

  localparam logic ERR_UNKNOWN = 1'b0;
  localparam logic ERR_BASE = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] token_code;
    logic [7:0] value_char;
    logic [1:0] number_base;
    logic [15:0] bit_width;
    logic [LineBits-1:0] token_line;
    logic [ColBits-1:0] token_column;
    logic error_code;
    logic last_of_run;
  } res_t;

  // Results of one byte, up to four, packed in order.
  typedef struct packed {
    logic [2:0] count;
    res_t [3:0] r;
  } burst_t;

  typedef logic [KwChars-1:0][7:0] kwbuf_t;

  function automatic logic [4:0] kw_code(input kwbuf_t b, input logic [KlenBits-1:0] n);
    logic [4:0] c;
    c = TK_IDENT;
    if (n == KlenBits'(4) && b[3:0] == {"E","R","I","W"}) c = TK_WIRE;
    if (n == KlenBits'(6) && b[5:0] == {"E","L","U","D","O","M"}) c = TK_MODULE;
    if (n == KlenBits'(9) && b[8:0] == {"E","L","U","D","O","M","D","N","E"}) c = TK_ENDMODULE;
    if (n == KlenBits'(6) && b[5:0] == {"N","G","I","S","S","A"}) c = TK_ASSIGN;
    if (n == KlenBits'(5) && b[4:0] == {"T","U","P","N","I"}) c = TK_INPUT;
    if (n == KlenBits'(6) && b[5:0] == {"T","U","P","T","U","O"}) c = TK_OUTPUT;
    return c;
  endfunction

  function automatic logic [4:0] punct(input logic [7:0] c);
    logic [4:0] p;
    case (c)
      ")": p = TK_RPAREN;
      "[": p = TK_LBRACK;
      "]": p = TK_RBRACK;
      "{": p = TK_LBRACE;
      "}": p = TK_RBRACE;
      "=": p = TK_EQ;
      ",": p = TK_COMMA;
      ".": p = TK_DOT;
      ";": p = TK_SEMI;
      ":": p = TK_COLON;
      default: p = PUNCT_NONE;
    endcase
    return p;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/netlist_text_tokenizer.sv
// Top level: netlist text tokenizer, front lexer plus result queue.
//
// Input channel: in_ch / in_end_of_source, taken when in_push and !in_full.
// Result channel: out_* fields show the oldest result while !out_empty;
// taken when out_pop and !out_empty.
// Each byte is lexed in the cycle it is taken and yields zero to three
// results, written into a 16-entry queue at once; the output shows the
// queue head combinationally.
// Throughput: one byte per cycle while in_full is low; the queue drains one
// result per cycle while popped, so sustained rate is bounded by results
// per byte on the output side. in_full rises when fewer than four queue
// slots remain free, so a stalled receiver backs the source up without
// losing results. A byte flagged end_of_source flushes the pending token
// and returns the lexer to its reset state for the next source.
// Synchronous active-low reset clears the lexer state and empties the queue.
`default_nettype none
module netlist_text_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_end_of_source,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_kind,
  output logic [4:0]       out_token_code,
  output logic [7:0]       out_value_char,
  output logic [1:0]       out_number_base,
  output logic [15:0]      out_bit_width,
  output logic [ntt_pkg::LineBits-1:0] out_token_line,
  output logic [ntt_pkg::ColBits-1:0]  out_token_column,
  output logic             out_error_code,
  output logic             out_last_of_run
);
  ntt_pkg::burst_t burst;
  ntt_pkg::res_t head;
  logic room, take;

  assign in_full = !room;
  assign take = in_push && room;

  ntt_front u_front (.clk, .rst_n, .take, .ch(in_ch), .eos(in_end_of_source), .burst);

  ntt_queue u_queue (.clk, .rst_n, .wr(take), .burst, .room, .rd(out_pop),
                     .empty(out_empty), .head);

  assign out_kind = head.kind;
  assign out_token_code = head.token_code;
  assign out_value_char = head.value_char;
  assign out_number_base = head.number_base;
  assign out_bit_width = head.bit_width;
  assign out_token_line = head.token_line;
  assign out_token_column = head.token_column;
  assign out_error_code = head.error_code;
  assign out_last_of_run = head.last_of_run;

  // a byte never yields more than four results
  a_burst_max: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> burst.count <= 3'd4) else $error("burst too long");
  // a burst's last result is flagged
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (take && burst.count != 3'd0) |-> burst.r[burst.count[1:0] - 2'd1].last_of_run)
    else $error("last_of_run missing");
  // errors only carry error codes
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != ntt_pkg::KIND_ERR) |-> !out_error_code)
    else $error("stray error code");
endmodule
`default_nettype wire

### hw/rtl/ntt_front.sv
// Front end: lexer state machine, position tracking, one burst per byte.
`default_nettype none
module ntt_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [7:0]        ch,
  input  wire logic              eos,
  output ntt_pkg::burst_t        burst
);
  ntt_pkg::mode_t mode_r, mode_nxt;
  ntt_pkg::kwbuf_t kw_r, kw_nxt;
  logic [ntt_pkg::KlenBits-1:0] klen_r, klen_nxt;
  logic [ntt_pkg::LineBits-1:0] line_r, line_nxt, sline_r, sline_nxt;
  logic [ntt_pkg::ColBits-1:0] col_r, col_nxt, scol_r, scol_nxt;
  logic [15:0] wacc_r, wacc_nxt;
  logic halt_r, halt_nxt;
  logic [1:0] pair_r, pair_nxt; // 0 none, 1 expect LF, 2 expect CR
  ntt_pkg::burst_t b;

  function automatic logic isdig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic isalp(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic logic issp(input logic [7:0] c);
    return c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd32;
  endfunction

  always_comb begin
    ntt_pkg::mode_t m;
    logic [1:0] base;
    logic [19:0] wmul;
    logic [7:0] up;
    logic [4:0] pc;
    logic re;
    logic [2:0] n;
    ntt_pkg::res_t rr;
    mode_nxt = mode_r; kw_nxt = kw_r; klen_nxt = klen_r;
    line_nxt = line_r; col_nxt = col_r; sline_nxt = sline_r; scol_nxt = scol_r;
    wacc_nxt = wacc_r; halt_nxt = halt_r; pair_nxt = pair_r;
    b = '0;
    n = 3'd0;
    rr = '0;
    re = 1'b0;
    m = mode_r;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    base = (m == ntt_pkg::M_HEX) ? ntt_pkg::BASE_HEX : (m == ntt_pkg::M_DEC) ? ntt_pkg::BASE_DEC :
           (m == ntt_pkg::M_BIN) ? ntt_pkg::BASE_BIN : ntt_pkg::BASE_PLAIN;
    wmul = {4'd0, wacc_r} * 20'd10 + {12'd0, ch - "0"};
    pc = ntt_pkg::punct(ch);
    if (!halt_r) begin
      // first pass: the mode's own handling; re marks relex in idle
      case (m)
        ntt_pkg::M_INT:
          if (isdig(ch)) begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_INT, value_char: ch,
                            token_line: sline_r, token_column: scol_r, default: '0};
            n = n + 3'd1;
            wacc_nxt = (wmul > 20'd65535) ? 16'hFFFF : wmul[15:0];
          end else if (ch == "'") mode_nxt = ntt_pkg::M_TICK;
          else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: ntt_pkg::TK_INT,
                            token_line: sline_r, token_column: scol_r, default: '0};
            n = n + 3'd1; re = 1'b1;
          end
        ntt_pkg::M_TICK:
          if (ch == "h") mode_nxt = ntt_pkg::M_HEX;
          else if (ch == "d") mode_nxt = ntt_pkg::M_DEC;
          else if (ch == "b") mode_nxt = ntt_pkg::M_BIN;
          else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_ERR, value_char: ch, token_line: line_r,
                            token_column: col_r, error_code: ntt_pkg::ERR_BASE, default: '0};
            n = n + 3'd1; halt_nxt = 1'b1;
          end
        ntt_pkg::M_HEX, ntt_pkg::M_DEC, ntt_pkg::M_BIN:
          if ((m == ntt_pkg::M_HEX && (isdig(ch) || (ch >= "a" && ch <= "f") ||
               (ch >= "A" && ch <= "F") || ch == "X")) ||
              (m == ntt_pkg::M_DEC && isdig(ch)) ||
              (m == ntt_pkg::M_BIN && (ch == "0" || ch == "1"))) begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_INT,
                            value_char: (ch == "X") ? "0" : ch, number_base: base,
                            bit_width: wacc_r, token_line: sline_r, token_column: scol_r,
                            default: '0};
            n = n + 3'd1;
          end else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: ntt_pkg::TK_INT,
                            number_base: base, bit_width: wacc_r, token_line: sline_r,
                            token_column: scol_r, default: '0};
            n = n + 3'd1; re = 1'b1;
          end
        ntt_pkg::M_IDENT:
          if (isdig(ch) || isalp(ch)) begin
            if (klen_r < ntt_pkg::KlenBits'(ntt_pkg::KwChars)) begin
              kw_nxt[klen_r[$clog2(ntt_pkg::KwChars)-1:0]] = up;
              klen_nxt = klen_r + 1'b1;
            end else klen_nxt = ntt_pkg::KlenBits'(ntt_pkg::KwChars + 1);
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_IDENT,
                            value_char: ch, token_line: sline_r, token_column: scol_r,
                            default: '0};
            n = n + 3'd1;
          end else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: ntt_pkg::kw_code(kw_r, klen_r),
                            token_line: sline_r, token_column: scol_r, default: '0};
            n = n + 3'd1; re = 1'b1;
          end
        ntt_pkg::M_ESC:
          if (issp(ch)) begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: ntt_pkg::TK_IDENT,
                            token_line: sline_r, token_column: scol_r, default: '0};
            n = n + 3'd1; mode_nxt = ntt_pkg::M_IDLE;
          end else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_IDENT,
                            value_char: ch, token_line: sline_r, token_column: scol_r,
                            default: '0};
            n = n + 3'd1;
          end
        ntt_pkg::M_LPAREN:
          if (ch == "*") mode_nxt = ntt_pkg::M_ATTR;
          else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: ntt_pkg::TK_LPAREN,
                            token_line: sline_r, token_column: scol_r, default: '0};
            n = n + 3'd1; re = 1'b1;
          end
        ntt_pkg::M_SLASH:
          if (ch == "*") mode_nxt = ntt_pkg::M_COMMENT;
          else if (ch == "/") mode_nxt = ntt_pkg::M_LINE_COMMENT;
          else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: ntt_pkg::TK_SLASH,
                            token_line: sline_r, token_column: scol_r, default: '0};
            n = n + 3'd1; re = 1'b1;
          end
        ntt_pkg::M_ATTR:
          if (ch == "*") mode_nxt = ntt_pkg::M_ATTR_STAR;
          else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_ATTR,
                            value_char: ch, token_line: sline_r, token_column: scol_r,
                            default: '0};
            n = n + 3'd1;
          end
        ntt_pkg::M_ATTR_STAR:
          if (ch == ")") begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: ntt_pkg::TK_ATTR,
                            token_line: sline_r, token_column: scol_r, default: '0};
            n = n + 3'd1; mode_nxt = ntt_pkg::M_IDLE;
          end else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_ATTR,
                            value_char: "*", token_line: sline_r, token_column: scol_r,
                            default: '0};
            n = n + 3'd1;
            if (ch != "*") begin
              b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_ATTR,
                              value_char: ch, token_line: sline_r, token_column: scol_r,
                              default: '0};
              n = n + 3'd1; mode_nxt = ntt_pkg::M_ATTR;
            end
          end
        ntt_pkg::M_COMMENT:
          if (ch == "*") mode_nxt = ntt_pkg::M_COMMENT_STAR;
        ntt_pkg::M_COMMENT_STAR:
          if (ch == "/") mode_nxt = ntt_pkg::M_IDLE;
          else if (ch != "*") mode_nxt = ntt_pkg::M_COMMENT;
        ntt_pkg::M_LINE_COMMENT:
          if (ch == 8'd10 || ch == 8'd13) mode_nxt = ntt_pkg::M_IDLE;
        default: re = 1'b1;
      endcase
      // idle handling of the byte, fresh or after a token end
      if (re) begin
        mode_nxt = ntt_pkg::M_IDLE;
        if (!issp(ch)) begin
          sline_nxt = line_r; scol_nxt = col_r;
          if (isdig(ch)) begin
            mode_nxt = ntt_pkg::M_INT;
            wacc_nxt = {8'd0, ch - "0"};
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_INT, value_char: ch,
                            token_line: line_r, token_column: col_r, default: '0};
            n = n + 3'd1;
          end else if (isalp(ch)) begin
            mode_nxt = ntt_pkg::M_IDENT;
            kw_nxt[0] = up;
            klen_nxt = ntt_pkg::KlenBits'(1);
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_VAL, token_code: ntt_pkg::TK_IDENT,
                            value_char: ch, token_line: line_r, token_column: col_r,
                            default: '0};
            n = n + 3'd1;
          end else if (ch == "(") mode_nxt = ntt_pkg::M_LPAREN;
          else if (ch == "\\") mode_nxt = ntt_pkg::M_ESC;
          else if (ch == "/") mode_nxt = ntt_pkg::M_SLASH;
          else if (pc != ntt_pkg::PUNCT_NONE) begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_TOK, token_code: pc, token_line: line_r,
                            token_column: col_r, default: '0};
            n = n + 3'd1;
          end else begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_ERR, value_char: ch, token_line: line_r,
                            token_column: col_r, error_code: ntt_pkg::ERR_UNKNOWN,
                            default: '0};
            n = n + 3'd1;
          end
        end
      end
      // position, skipped when this byte halted the lexer
      if (!halt_nxt) begin
        if (ch == 8'd10 || ch == 8'd13) begin
          if ((ch == 8'd10 && pair_r == 2'd1) || (ch == 8'd13 && pair_r == 2'd2))
            pair_nxt = 2'd0;
          else begin
            if (line_r != ntt_pkg::LineTop) line_nxt = line_r + 1'b1;
            col_nxt = ntt_pkg::ColBits'(1);
            pair_nxt = (ch == 8'd10) ? 2'd2 : 2'd1;
          end
        end else begin
          pair_nxt = 2'd0;
          if (col_r != ntt_pkg::ColTop) col_nxt = col_r + 1'b1;
        end
      end
    end
    if (eos) begin
      if (!halt_nxt) begin
        rr = '{kind: ntt_pkg::KIND_TOK, token_line: sline_nxt, token_column: scol_nxt,
               default: '0};
        case (mode_nxt)
          ntt_pkg::M_INT: begin b.r[n[1:0]] = rr; n = n + 3'd1; end
          ntt_pkg::M_TICK: begin
            b.r[n[1:0]] = '{kind: ntt_pkg::KIND_ERR, token_line: line_nxt,
                            token_column: col_nxt, error_code: ntt_pkg::ERR_BASE,
                            default: '0};
            n = n + 3'd1;
          end
          ntt_pkg::M_HEX, ntt_pkg::M_DEC, ntt_pkg::M_BIN: begin
            rr.number_base = (mode_nxt == ntt_pkg::M_HEX) ? ntt_pkg::BASE_HEX :
                             (mode_nxt == ntt_pkg::M_DEC) ? ntt_pkg::BASE_DEC :
                             ntt_pkg::BASE_BIN;
            rr.bit_width = wacc_nxt;
            b.r[n[1:0]] = rr; n = n + 3'd1;
          end
          ntt_pkg::M_IDENT: begin
            rr.token_code = ntt_pkg::kw_code(kw_nxt, klen_nxt);
            b.r[n[1:0]] = rr; n = n + 3'd1;
          end
          ntt_pkg::M_ESC: begin
            rr.token_code = ntt_pkg::TK_IDENT; b.r[n[1:0]] = rr; n = n + 3'd1;
          end
          ntt_pkg::M_LPAREN: begin
            rr.token_code = ntt_pkg::TK_LPAREN; b.r[n[1:0]] = rr; n = n + 3'd1;
          end
          ntt_pkg::M_SLASH: begin
            rr.token_code = ntt_pkg::TK_SLASH; b.r[n[1:0]] = rr; n = n + 3'd1;
          end
          default: ;
        endcase
      end
      mode_nxt = ntt_pkg::M_IDLE; kw_nxt = '0; klen_nxt = '0;
      line_nxt = ntt_pkg::LineBits'(1); col_nxt = ntt_pkg::ColBits'(1);
      sline_nxt = ntt_pkg::LineBits'(1); scol_nxt = ntt_pkg::ColBits'(1);
      wacc_nxt = '0; halt_nxt = 1'b0; pair_nxt = 2'd0;
    end
    if (n != 3'd0) b.r[n[1:0] - 2'd1].last_of_run = 1'b1;
    b.count = n;
  end

  assign burst = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ntt_pkg::M_IDLE; kw_r <= '0; klen_r <= '0;
      line_r <= ntt_pkg::LineBits'(1); col_r <= ntt_pkg::ColBits'(1);
      sline_r <= ntt_pkg::LineBits'(1); scol_r <= ntt_pkg::ColBits'(1);
      wacc_r <= '0; halt_r <= 1'b0; pair_r <= 2'd0;
    end else if (take) begin
      mode_r <= mode_nxt; kw_r <= kw_nxt; klen_r <= klen_nxt;
      line_r <= line_nxt; col_r <= col_nxt; sline_r <= sline_nxt; scol_r <= scol_nxt;
      wacc_r <= wacc_nxt; halt_r <= halt_nxt; pair_r <= pair_nxt;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/ntt_queue.sv
// Result queue: takes bursts of up to four results, drains one per cycle on rd.
`default_nettype none
module ntt_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr,
  input  wire ntt_pkg::burst_t   burst,
  output logic                   room,
  input  wire logic              rd,
  output logic                   empty,
  output ntt_pkg::res_t          head
);
  ntt_pkg::res_t mem [ntt_pkg::QDepth];
  logic [ntt_pkg::QPtrBits-1:0] wp_r, rp_r;
  logic [ntt_pkg::CntBits-1:0] cnt_r;
  logic [2:0] nwr;
  logic pop;

  assign empty = (cnt_r == '0);
  assign pop = rd && !empty;
  assign nwr = wr ? burst.count : 3'd0;
  // room for a full burst even without a pop this cycle
  assign room = (cnt_r <= ntt_pkg::CntBits'(ntt_pkg::QDepth - 4));
  assign head = mem[rp_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++)
      if (wr && 3'(i) < burst.count) mem[wp_r + ntt_pkg::QPtrBits'(i)] <= burst.r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + ntt_pkg::QPtrBits'(nwr);
      rp_r <= rp_r + ntt_pkg::QPtrBits'(pop);
      cnt_r <= cnt_r + ntt_pkg::CntBits'(nwr) - ntt_pkg::CntBits'(pop);
    end
  end
endmodule
`default_nettype wire
